// File: rtl/spp_pkg.sv
// ---------------------------------------------------------------------------
// Sphere point projector package
// Shared widths, register indexes, payload types, controller states and
// saturation helper.
// ---------------------------------------------------------------------------
package spp_pkg;

  localparam int COORD_BITS = 32;
  localparam int FRAC_BITS  = 16;
  localparam int RAD_BITS   = 31;
  localparam int LEN_BITS   = 32;
  localparam int MAG_BITS   = COORD_BITS + 1;
  localparam int WIDE_BITS  = COORD_BITS + 2;
  localparam int PROD_BITS  = 2 * MAG_BITS;
  localparam int SUM_BITS   = 2 * MAG_BITS + 2;
  localparam int ROOT_BITS  = SUM_BITS / 2;
  localparam int NUM_BITS   = 2 * COORD_BITS;
  localparam int QUOT_BITS  = COORD_BITS;

  localparam int CFG_IDX_BITS = 3;
  localparam logic [CFG_IDX_BITS-1:0] REG_CENTRE_X      = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_CENTRE_Y      = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_CENTRE_Z      = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPHERE_RADIUS = 3'd3;

  localparam logic [RAD_BITS-1:0] RADIUS_RESET = RAD_BITS'(1) << FRAC_BITS;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic signed [COORD_BITS-1:0] point_z;
  } point_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] proj_x;
    logic signed [COORD_BITS-1:0] proj_y;
    logic signed [COORD_BITS-1:0] proj_z;
    logic signed [COORD_BITS-1:0] move_x;
    logic signed [COORD_BITS-1:0] move_y;
    logic signed [COORD_BITS-1:0] move_z;
    logic        [LEN_BITS-1:0]   move_length;
    logic        [LEN_BITS-1:0]   largest_move;
    logic                         at_centre_error;
  } result_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SQ,
    ST_ROOT_GO,
    ST_ROOT_WAIT,
    ST_MUL,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_FIX_PROJ,
    ST_FIX_MOVE,
    ST_DONE
  } state_t;

  // Clamp a widened signed value to the coordinate range.
  function automatic logic signed [COORD_BITS-1:0] sat_coord(
    input logic signed [WIDE_BITS-1:0] v
  );
    logic signed [WIDE_BITS-1:0] hi_lim;
    logic signed [WIDE_BITS-1:0] lo_lim;
    hi_lim = WIDE_BITS'({1'b0, {(COORD_BITS-1){1'b1}}});
    lo_lim = -hi_lim - WIDE_BITS'(1);
    if (v > hi_lim) begin
      sat_coord = hi_lim[COORD_BITS-1:0];
    end else if (v < lo_lim) begin
      sat_coord = lo_lim[COORD_BITS-1:0];
    end else begin
      sat_coord = v[COORD_BITS-1:0];
    end
  endfunction

endpackage

// File: rtl/spp_sqrt.sv
// ---------------------------------------------------------------------------
// Bit-serial square root
// Floor square root of the sum of squares, two radicand bits shifted in
// and one root bit produced per cycle.
// ---------------------------------------------------------------------------
module spp_sqrt (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [spp_pkg::SUM_BITS-1:0]     radicand,
  output logic                             done,
  output logic [spp_pkg::ROOT_BITS-1:0]    root
);

  localparam int REM_BITS = spp_pkg::ROOT_BITS + 2;

  logic [spp_pkg::SUM_BITS-1:0] rad;
  logic [REM_BITS-1:0]          rem;
  logic [5:0]                   cnt;
  logic                         busy;
  logic [REM_BITS+1:0]          rem_sh;
  logic [REM_BITS+1:0]          trial;
  logic                         fit;

  assign rem_sh = {rem, rad[spp_pkg::SUM_BITS-1 -: 2]};
  assign trial  = {2'b00, root, 2'b01};
  assign fit    = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rad  <= radicand;
        rem  <= '0;
        root <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        rad  <= {rad[spp_pkg::SUM_BITS-3:0], 2'b00};
        rem  <= fit ? REM_BITS'(rem_sh - trial) : rem_sh[REM_BITS-1:0];
        root <= {root[spp_pkg::ROOT_BITS-2:0], fit};
        cnt  <= cnt + 6'd1;
        if (cnt == 6'(spp_pkg::ROOT_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// File: rtl/spp_div.sv
// ---------------------------------------------------------------------------
// Bit-serial divider
// Restoring division, one quotient bit per cycle. The caller guarantees
// that the quotient fits in the coordinate width.
// ---------------------------------------------------------------------------
module spp_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [spp_pkg::NUM_BITS-1:0]     num,
  input  logic [spp_pkg::ROOT_BITS-1:0]    den,
  output logic                             done,
  output logic [spp_pkg::QUOT_BITS-1:0]    quot
);

  localparam int RB = spp_pkg::ROOT_BITS;
  localparam int QB = spp_pkg::QUOT_BITS;

  logic [RB-1:0] rem;
  logic [4:0]    cnt;
  logic          busy;
  logic [RB:0]   rs;
  logic          fit;

  assign rs  = {rem, quot[QB-1]};
  assign fit = rs >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= RB'(num[spp_pkg::NUM_BITS-1:QB]);
        quot <= num[QB-1:0];
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        rem  <= fit ? RB'(rs - {1'b0, den}) : rs[RB-1:0];
        quot <= {quot[QB-2:0], fit};
        cnt  <= cnt + 5'd1;
        if (cnt == 5'(QB - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// File: rtl/sphere_point_projector.sv
// ---------------------------------------------------------------------------
// Sphere point projector
// Projects each point radially onto the configured sphere and reports the
// projected point, the displacement, its length and the largest length.
// ---------------------------------------------------------------------------
// One point is worked on at a time: each point off the centre takes three
// serial divisions and two serial square roots, and the controller returns
// to idle before it accepts the next transfer. A point at the centre is not
// projected; it is returned unchanged with the at-centre error flag set. A
// stalled result holds the next transfer.
// Reset (synchronous, active high) clears the controller, the output valid,
// the largest displacement, the centre to the origin and the radius to 1.0.
module sphere_point_projector (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  spp_pkg::point_t                      in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output spp_pkg::result_t                     out_data,
  input  logic                                 cfg_we,
  input  logic [spp_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [spp_pkg::COORD_BITS-1:0]       cfg_data
);

  localparam int CB = spp_pkg::COORD_BITS;
  localparam int MB = spp_pkg::MAG_BITS;
  localparam int WB = spp_pkg::WIDE_BITS;

  // Configuration registers. The centre is kept as an array so that the
  // component counter can pick the active axis.
  logic signed [CB-1:0]            centre [3];
  logic [spp_pkg::RAD_BITS-1:0]    sphere_radius;

  spp_pkg::state_t state;
  spp_pkg::state_t state_next;

  // Working registers for the item in flight.
  logic signed [CB-1:0]            pnt [3];
  logic signed [CB-1:0]            prj [3];
  logic signed [CB-1:0]            mov [3];
  logic [MB-1:0]                   mag [3];
  logic                            neg [3];
  logic [1:0]                      idx;
  logic [1:0]                      sq_cnt;
  logic                            second_pass;
  logic                            at_centre;
  logic [spp_pkg::SUM_BITS-1:0]    acc;
  logic [spp_pkg::PROD_BITS-1:0]   prod;
  logic [spp_pkg::ROOT_BITS-1:0]   offset_len;
  logic [spp_pkg::LEN_BITS-1:0]    len;
  logic [spp_pkg::LEN_BITS-1:0]    max_move_seen;
  logic [spp_pkg::LEN_BITS-1:0]    max_move_seen_next;

  // Control decoded from the state.
  logic                            root_start;
  logic                            div_start;
  logic                            out_load;

  logic                            root_done;
  logic [spp_pkg::ROOT_BITS-1:0]   root;
  logic                            div_done;
  logic [spp_pkg::QUOT_BITS-1:0]   quot;
  logic [spp_pkg::NUM_BITS-1:0]    div_num;

  logic [MB-1:0]                   mul_a;
  logic [MB-1:0]                   mul_b;
  logic signed [WB-1:0]            d_wide [3];
  logic signed [WB-1:0]            proj_sum;
  logic signed [WB-1:0]            move_diff;
  logic signed [CB-1:0]            move_sat;

  spp_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (root_start),
    .radicand (acc),
    .done     (root_done),
    .root     (root)
  );

  // Rounding to nearest: half the divisor is added before the division.
  assign div_num = prod[spp_pkg::NUM_BITS-1:0]
                 + spp_pkg::NUM_BITS'(offset_len[spp_pkg::ROOT_BITS-1:1]);

  spp_div u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (div_num),
    .den  (offset_len),
    .done (div_done),
    .quot (quot)
  );

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      spp_pkg::ST_IDLE: begin
        if (in_valid) state_next = spp_pkg::ST_LOAD;
      end
      spp_pkg::ST_LOAD: begin
        state_next = spp_pkg::ST_SQ;
      end
      spp_pkg::ST_SQ: begin
        if (at_centre) begin
          state_next = spp_pkg::ST_DONE;
        end else if (sq_cnt == 2'd3) begin
          state_next = spp_pkg::ST_ROOT_GO;
        end
      end
      spp_pkg::ST_ROOT_GO: begin
        state_next = spp_pkg::ST_ROOT_WAIT;
      end
      spp_pkg::ST_ROOT_WAIT: begin
        if (root_done) begin
          state_next = second_pass ? spp_pkg::ST_DONE : spp_pkg::ST_MUL;
        end
      end
      spp_pkg::ST_MUL: begin
        state_next = spp_pkg::ST_DIV_GO;
      end
      spp_pkg::ST_DIV_GO: begin
        state_next = spp_pkg::ST_DIV_WAIT;
      end
      spp_pkg::ST_DIV_WAIT: begin
        if (div_done) state_next = spp_pkg::ST_FIX_PROJ;
      end
      spp_pkg::ST_FIX_PROJ: begin
        state_next = spp_pkg::ST_FIX_MOVE;
      end
      spp_pkg::ST_FIX_MOVE: begin
        state_next = (idx == 2'd2) ? spp_pkg::ST_SQ : spp_pkg::ST_MUL;
      end
      spp_pkg::ST_DONE: begin
        if (!out_valid || out_ready) state_next = spp_pkg::ST_IDLE;
      end
      default: begin
        state_next = spp_pkg::ST_IDLE;
      end
    endcase
  end

  // Output decode of the controller.
  always_comb begin
    in_ready   = 1'b0;
    root_start = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    case (state)
      spp_pkg::ST_IDLE:     in_ready   = 1'b1;
      spp_pkg::ST_ROOT_GO:  root_start = 1'b1;
      spp_pkg::ST_DIV_GO:   div_start  = 1'b1;
      spp_pkg::ST_DONE:     out_load   = !out_valid || out_ready;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // The shared multiplier squares magnitudes during the sum of squares and
  // scales by the radius before each division.
  always_comb begin
    if (state == spp_pkg::ST_MUL) begin
      mul_a = MB'(sphere_radius);
      mul_b = mag[idx];
    end else begin
      mul_a = mag[sq_cnt];
      mul_b = mag[sq_cnt];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_wide[i] = WB'(pnt[i]) - WB'(centre[i]);
    end
  end

  assign proj_sum  = neg[idx] ? WB'(centre[idx]) - WB'({1'b0, quot})
                              : WB'(centre[idx]) + WB'({1'b0, quot});
  assign move_diff = WB'(prj[idx]) - WB'(pnt[idx]);
  assign move_sat  = spp_pkg::sat_coord(move_diff);

  always_comb begin
    max_move_seen_next = max_move_seen;
    if (!at_centre && len > max_move_seen) max_move_seen_next = len;
  end

  // Configuration writes; an index beyond the register list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      centre[0]     <= '0;
      centre[1]     <= '0;
      centre[2]     <= '0;
      sphere_radius <= spp_pkg::RADIUS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        spp_pkg::REG_CENTRE_X:      centre[0] <= cfg_data;
        spp_pkg::REG_CENTRE_Y:      centre[1] <= cfg_data;
        spp_pkg::REG_CENTRE_Z:      centre[2] <= cfg_data;
        spp_pkg::REG_SPHERE_RADIUS: sphere_radius <= cfg_data[spp_pkg::RAD_BITS-1:0];
        default: begin
          sphere_radius <= sphere_radius;
        end
      endcase
    end
  end

  // Controller state, result valid and largest displacement.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= spp_pkg::ST_IDLE;
      out_valid     <= 1'b0;
      max_move_seen <= '0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid     <= 1'b1;
        max_move_seen <= max_move_seen_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    case (state)
      spp_pkg::ST_IDLE: begin
        pnt[0] <= in_data.point_x;
        pnt[1] <= in_data.point_y;
        pnt[2] <= in_data.point_z;
        second_pass <= 1'b0;
      end
      spp_pkg::ST_LOAD: begin
        for (int i = 0; i < 3; i++) begin
          neg[i] <= d_wide[i] < 0;
          mag[i] <= (d_wide[i] < 0) ? MB'(-d_wide[i]) : MB'(d_wide[i]);
          prj[i] <= pnt[i];
          mov[i] <= '0;
        end
        at_centre <= (d_wide[0] == 0) && (d_wide[1] == 0) && (d_wide[2] == 0);
        len       <= '0;
        acc       <= '0;
        sq_cnt    <= '0;
      end
      spp_pkg::ST_SQ: begin
        // Squares leave the multiplier register in the cycle after issue.
        if (sq_cnt != 2'd0) acc <= acc + spp_pkg::SUM_BITS'(prod);
        sq_cnt <= sq_cnt + 2'd1;
      end
      spp_pkg::ST_ROOT_WAIT: begin
        if (root_done) begin
          idx <= '0;
          if (second_pass) begin
            len <= (root[spp_pkg::ROOT_BITS-1:spp_pkg::LEN_BITS] != '0)
                   ? '1 : root[spp_pkg::LEN_BITS-1:0];
          end else begin
            offset_len <= root;
          end
        end
      end
      spp_pkg::ST_FIX_PROJ: begin
        prj[idx] <= spp_pkg::sat_coord(proj_sum);
      end
      spp_pkg::ST_FIX_MOVE: begin
        mov[idx] <= move_sat;
        mag[idx] <= move_sat[CB-1] ? MB'(-WB'(move_sat)) : MB'(move_sat);
        idx      <= idx + 2'd1;
        if (idx == 2'd2) begin
          second_pass <= 1'b1;
          acc         <= '0;
          sq_cnt      <= '0;
        end
      end
      default: begin
        acc <= acc;
      end
    endcase
    if (out_load) begin
      out_data.proj_x          <= prj[0];
      out_data.proj_y          <= prj[1];
      out_data.proj_z          <= prj[2];
      out_data.move_x          <= mov[0];
      out_data.move_y          <= mov[1];
      out_data.move_z          <= mov[2];
      out_data.move_length     <= len;
      out_data.largest_move    <= max_move_seen_next;
      out_data.at_centre_error <= at_centre;
    end
  end

endmodule

// File: rtl/spp_checker.sv
// ---------------------------------------------------------------------------
// Sphere point projector port checker
// Watches the top-level ports over time and is bound to the top level.
// ---------------------------------------------------------------------------
module spp_checker (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_ready,
  input  logic             out_valid,
  input  logic             out_ready,
  input  spp_pkg::result_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  a_centre_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.at_centre_error |->
      out_data.move_length == '0 && out_data.move_x == '0 &&
      out_data.move_y == '0 && out_data.move_z == '0)
    else $error("point at centre shows a displacement");

  a_max_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.largest_move >= out_data.move_length)
    else $error("largest displacement below current displacement");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("block not idle after reset");

endmodule

bind sphere_point_projector spp_checker u_spp_checker (
  .clk      (clk),
  .rst      (rst),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);
